[src/pdh_pkg.sv]
// Package: shared constants and command codes for the pair distance histogram.
package pdh_pkg;

    localparam int MAX_BINS_DEF    = 256;
    localparam int COORD_WIDTH_DEF = 24;
    localparam int COUNT_WIDTH_DEF = 32;

    localparam int LEN_W  = 23;
    localparam int BINS_W = 9;

    typedef enum logic [1:0] {
        CMD_ADD   = 2'd0,
        CMD_FRAME = 2'd1,
        CMD_READ  = 2'd2,
        CMD_CLEAR = 2'd3
    } cmd_t;

    typedef enum logic [1:0] {
        REG_BOX      = 2'd0,
        REG_PERIODIC = 2'd1,
        REG_CUTOFF   = 2'd2,
        REG_BINS     = 2'd3
    } reg_idx_t;

endpackage

[src/pair_distance_histogram_top.sv]
// Top level: pair distance histogram with a memory-held bin array.
//
//  channel  | group        | payload
//  input    | s_axis_*     | tdata: cmd, sep_x, sep_y, sep_z, bin_select
//  output   | m_axis_*     | tdata: in_range, bin_index, bin_count, sample_total
//  config   | cfg_*        | index 0 box, 1 periodic, 2 cutoff, 3 bins
//
// One item at a time. An add beat that is counted passes through: fold at acceptance,
// square, then sum, a 25-step (COORD_WIDTH + 1) bit-pair square root, a range check,
// a 10-step (AW + 2) restoring division, then memory read, wait, modify/write and
// output. A pair beyond the cutoff skips the division and memory steps; a read beat
// goes through wait and modify to output, and a frame beat goes straight to output.
// A clear beat's result is valid in the cycle after acceptance; then, as after reset,
// a clearing pass sweeps all MAX_BINS bins (one bin a cycle) with s_axis_tready low.
// The result beat is held in an output register; no input is taken until it is taken.
module pair_distance_histogram_top
#(
    parameter int MAX_BINS    = pdh_pkg::MAX_BINS_DEF,
    parameter int COORD_WIDTH = pdh_pkg::COORD_WIDTH_DEF,
    parameter int COUNT_WIDTH = pdh_pkg::COUNT_WIDTH_DEF
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [22:0] cfg_data,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // cmd[1:0], sep_x, sep_y, sep_z, bin_select, zero fill
    input  logic [((2 + 3 * COORD_WIDTH + 8 + 7) / 8) * 8 - 1:0] s_axis_tdata,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // in_range, bin_index[7:0], bin_count[31:0], sample_total[31:0], zero fill
    output logic [79:0] m_axis_tdata
);
    import pdh_pkg::*;

    localparam int AW   = $clog2(MAX_BINS);
    localparam int SQW  = 2 * COORD_WIDTH + 2;
    localparam int RW   = SQW / 2 + 1;
    localparam int ITER = (SQW + 1) / 2;
    localparam int QW   = AW + 2;
    localparam int BW   = BINS_W > AW + 1 ? BINS_W : AW + 1;
    localparam int FW   = (COORD_WIDTH > LEN_W ? COORD_WIDTH : LEN_W) + 2;
    localparam logic [COUNT_WIDTH-1:0] CMAX = '1;

    typedef enum logic [3:0] {
        S_CLEAR, S_IDLE, S_SQ, S_SUM, S_SQRT, S_DIVSET, S_DIV,
        S_RD, S_WAIT, S_WR, S_OUT
    } state_t;

    // configuration
    logic [LEN_W-1:0]  box_reg, cut_reg;
    logic              per_reg;
    logic [BINS_W-1:0] bins_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            box_reg  <= '0;
            per_reg  <= 1'b1;
            cut_reg  <= '0;
            bins_reg <= 9'd256;
        end
        else if (cfg_we)
        begin
            case (reg_idx_t'(cfg_index))
                REG_BOX:      box_reg  <= cfg_data;
                REG_PERIODIC: per_reg  <= cfg_data[0];
                REG_CUTOFF:   cut_reg  <= cfg_data;
                REG_BINS:     bins_reg <= cfg_data[BINS_W-1:0];
                default:      ;
            endcase
        end
    end

    // effective cutoff and bin count
    logic [LEN_W-1:0] half, c_eff, c_pre;
    logic [BW-1:0]    bins_eff;
    always_comb
    begin
        half  = box_reg >> 1;
        c_pre = (cut_reg != '0) ? cut_reg : half;
        c_eff = (per_reg && c_pre > half) ? half : c_pre;
        if (bins_reg == '0)
            bins_eff = BW'(1);
        else if (BW'(bins_reg) > BW'(MAX_BINS))
            bins_eff = BW'(MAX_BINS);
        else
            bins_eff = BW'(bins_reg);
    end

    // input fields
    logic [1:0]                   in_cmd;
    logic signed [COORD_WIDTH-1:0] in_sep [3];
    logic [7:0]                   in_bsel;
    assign in_cmd    = s_axis_tdata[1:0];
    assign in_sep[0] = s_axis_tdata[2 +: COORD_WIDTH];
    assign in_sep[1] = s_axis_tdata[2 + COORD_WIDTH +: COORD_WIDTH];
    assign in_sep[2] = s_axis_tdata[2 + 2 * COORD_WIDTH +: COORD_WIDTH];
    assign in_bsel   = s_axis_tdata[2 + 3 * COORD_WIDTH +: 8];

    // fold one component to its minimum image, return magnitude
    function automatic logic [COORD_WIDTH:0] fold_mag(input logic signed [COORD_WIDTH-1:0] d,
                                                      input logic p,
                                                      input logic [LEN_W-1:0] l);
        logic signed [FW:0] dd, ll, f;
        dd = (FW+1)'(d);
        ll = (FW+1)'($signed({1'b0, l}));
        f  = dd;
        if (p && l != '0)
        begin
            if ((dd <<< 1) > ll)
                f = dd - ll;
            else if ((dd <<< 1) < -ll)
                f = dd + ll;
        end
        fold_mag = f[FW] ? (COORD_WIDTH+1)'(-f) : (COORD_WIDTH+1)'(f);
    endfunction

    // datapath registers
    state_t               st_reg;
    logic [1:0]           cmd_reg;
    logic [COORD_WIDTH:0] mag_reg [3];
    logic [SQW-3:0]       sq_reg  [3];
    logic [SQW-1:0]       root_reg;
    logic [SQW-1:0]       val_reg;
    logic [$clog2(ITER+1)-1:0] it_reg;
    logic [RW+BW-1:0]     num_reg;
    logic [QW-1:0]        quo_reg;
    logic [AW-1:0]        addr_reg;
    logic [COUNT_WIDTH-1:0] frame_reg, cnt_reg;
    logic                 hit_reg;
    logic                 out_v_reg;
    logic [79:0]          out_d_reg;

    // histogram memory
    logic [COUNT_WIDTH-1:0] hist_mem [MAX_BINS];
    logic [COUNT_WIDTH-1:0] rd_data;
    logic                   mem_we;
    logic [AW-1:0]          mem_wa;
    logic [COUNT_WIDTH-1:0] mem_wd;

    always_ff @(posedge clk)
    begin
        if (mem_we)
            hist_mem[mem_wa] <= mem_wd;
        rd_data <= hist_mem[addr_reg];
    end

    assign s_axis_tready = (st_reg == S_IDLE) && !out_v_reg;
    assign m_axis_tvalid = out_v_reg;
    assign m_axis_tdata  = out_d_reg;

    // square root step values
    logic [SQW-1:0] trial;
    logic [SQW-1:0] bitv;
    always_comb
    begin
        bitv  = SQW'(1) << (2 * (ITER - 1 - int'(it_reg)));
        trial = root_reg + bitv;
    end
    // division trial
    logic [RW+BW:0] dtrial;
    assign dtrial = {1'b0, num_reg} - ({(RW+BW+1-LEN_W)'(0), c_eff} << (QW - 1 - int'(it_reg)));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg    <= S_CLEAR;
            addr_reg  <= '0;
            frame_reg <= '0;
            out_v_reg <= 1'b0;
            mem_we    <= 1'b0;
        end
        else
        begin
            // write zeros while sweeping, or the updated count after a hit
            mem_we <= (st_reg == S_CLEAR) || (st_reg == S_WR && hit_reg);
            if (out_v_reg && m_axis_tready)
                out_v_reg <= 1'b0;
            case (st_reg)
                // sweep zeros through every bin
                S_CLEAR:
                begin
                    mem_wa <= addr_reg;
                    mem_wd <= '0;
                    addr_reg <= addr_reg + AW'(1);
                    if (addr_reg == AW'(MAX_BINS - 1))
                        st_reg <= S_IDLE;
                end
                S_IDLE:
                begin
                    if (s_axis_tvalid && s_axis_tready)
                    begin
                        cmd_reg <= in_cmd;
                        hit_reg <= 1'b0;
                        cnt_reg <= '0;
                        case (cmd_t'(in_cmd))
                            CMD_ADD:
                            begin
                                for (int i = 0; i < 3; i++)
                                    mag_reg[i] <= fold_mag(in_sep[i], per_reg, box_reg);
                                st_reg <= S_SQ;
                            end
                            CMD_FRAME:
                            begin
                                if (frame_reg != CMAX)
                                    frame_reg <= frame_reg + COUNT_WIDTH'(1);
                                st_reg <= S_OUT;
                            end
                            CMD_READ:
                            begin
                                addr_reg <= AW'(in_bsel);
                                st_reg   <= S_WAIT;
                            end
                            default:
                            begin
                                frame_reg <= '0;
                                addr_reg  <= '0;
                                out_v_reg <= 1'b1;
                                out_d_reg <= '0;
                                st_reg    <= S_CLEAR;
                            end
                        endcase
                    end
                end
                // square each magnitude
                S_SQ:
                begin
                    for (int i = 0; i < 3; i++)
                        sq_reg[i] <= (SQW-2)'(mag_reg[i] * mag_reg[i]);
                    st_reg <= S_SUM;
                end
                S_SUM:
                begin
                    val_reg  <= SQW'(sq_reg[0]) + SQW'(sq_reg[1]) + SQW'(sq_reg[2]);
                    root_reg <= '0;
                    it_reg   <= '0;
                    st_reg   <= S_SQRT;
                end
                // one bit pair per cycle
                S_SQRT:
                begin
                    if (val_reg >= trial)
                    begin
                        val_reg  <= val_reg - trial;
                        root_reg <= (root_reg >> 1) + bitv;
                    end
                    else
                        root_reg <= root_reg >> 1;
                    it_reg <= it_reg + 1'b1;
                    if (int'(it_reg) == ITER - 1)
                        st_reg <= S_DIVSET;
                end
                S_DIVSET:
                begin
                    if (c_eff != '0 && (RW+1)'(root_reg) < (RW+1)'(c_eff))
                    begin
                        num_reg <= (RW+BW)'(root_reg) * (RW+BW)'(bins_eff);
                        quo_reg <= '0;
                        it_reg  <= '0;
                        st_reg  <= S_DIV;
                    end
                    else
                        st_reg <= S_OUT;
                end
                // restoring division, one quotient bit a cycle
                S_DIV:
                begin
                    if (!dtrial[RW+BW])
                    begin
                        num_reg <= dtrial[RW+BW-1:0];
                        quo_reg <= quo_reg | (QW'(1) << (QW - 1 - int'(it_reg)));
                    end
                    it_reg <= it_reg + 1'b1;
                    if (int'(it_reg) == QW - 1)
                        st_reg <= S_RD;
                end
                S_RD:
                begin
                    addr_reg <= (quo_reg >= QW'(MAX_BINS)) ? AW'(MAX_BINS - 1) : AW'(quo_reg);
                    hit_reg  <= 1'b1;
                    st_reg   <= S_WAIT;
                end
                S_WAIT:
                    st_reg <= S_WR;
                // modify and write back after a hit; a read only takes the count
                S_WR:
                begin
                    if (hit_reg)
                    begin
                        cnt_reg <= (rd_data != CMAX) ? rd_data + COUNT_WIDTH'(1) : rd_data;
                        mem_wa  <= addr_reg;
                        mem_wd  <= (rd_data != CMAX) ? rd_data + COUNT_WIDTH'(1) : rd_data;
                    end
                    else
                        cnt_reg <= rd_data;
                    st_reg <= S_OUT;
                end
                S_OUT:
                begin
                    out_v_reg <= 1'b1;
                    out_d_reg <= {7'd0, 32'(frame_reg), 32'(cnt_reg),
                                  ((hit_reg || cmd_reg == CMD_READ) ? 8'(addr_reg) : 8'd0),
                                  hit_reg};
                    st_reg <= S_IDLE;
                end
                default:
                    st_reg <= S_IDLE;
            endcase
        end
    end

    // no input taken while a result waits
    a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> !s_axis_tready)
        else $error("input accepted while result pending");
    // result held while stalled
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && !m_axis_tready) |=> (m_axis_tvalid && $stable(m_axis_tdata)))
        else $error("result changed under stall");
    // a pair out of range reports no bin
    a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && !m_axis_tdata[0] && cmd_reg == CMD_ADD) |-> (m_axis_tdata[40:1] == '0))
        else $error("missed pair reports a bin");

endmodule
